### hw/rtl/bitmap_first_fit_allocator_macros.svh
// assertion helpers for the checker file
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication under a disable condition
`define BFFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bffa check failed");

// next-cycle implication under a disable condition
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bffa check failed");

`endif

### hw/rtl/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

   // map size default in bytes
   localparam int unsigned MAP_BYTES_DEF = 32;

   // field widths
   localparam int unsigned WORD_W  = 8;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned START_W = 8;
   localparam int unsigned LEN_W   = 9;
   localparam int unsigned RUN_W   = 8;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_SEARCH = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_FREE   = 2'd2
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_RESP
   } state_type;

   // command held for the duration of a scan
   typedef struct packed {
      cmd_type              cmd;
      logic [START_W-1:0]   start_bit;
      logic [LEN_W-1:0]     run_length;
   } op_type;

   // running state of a first-fit search
   typedef struct packed {
      logic                 hit;
      logic [LEN_W-1:0]     zeros;
      logic [RUN_W-1:0]     run_begin;
      logic [RUN_W-1:0]     where;
   } search_type;

endpackage

`default_nettype wire

### hw/rtl/bffa_mem.sv
`default_nettype none

module bffa_mem
   import bffa_pkg::*;
#(
   parameter int unsigned DEPTH = MAP_BYTES_DEF,
   parameter int unsigned AW    = 5
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [WORD_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/bffa_word.sv
`default_nettype none

module bffa_word
   import bffa_pkg::*;
#(
   parameter int unsigned BIT_W = 8
) (
   input  wire op_type            op,
   input  wire logic [BIT_W-1:0]  base,
   input  wire logic [WORD_W-1:0] word_in,
   input  wire search_type        srch_in,
   output logic      [WORD_W-1:0] word_out,
   output search_type             srch_out
);

   localparam int unsigned CW = (BIT_W > 10) ? BIT_W : 10;

   logic [CW-1:0] bit_idx;
   logic [CW-1:0] range_lo;
   logic [CW-1:0] range_hi;
   logic          in_range;
   search_type    s;
   logic [WORD_W-1:0] w;

   // one word: eight search steps or eight mark updates
   always_comb begin
      s        = srch_in;
      w        = word_in;
      bit_idx  = '0;
      in_range = 1'b0;
      range_lo = CW'(op.start_bit);
      range_hi = CW'(op.start_bit) + CW'(op.run_length);
      for (int j = 0; j < WORD_W; j++) begin
         bit_idx  = CW'(base) + CW'(j);
         in_range = (bit_idx >= range_lo) && (bit_idx < range_hi);
         case (op.cmd)
            CMD_SEARCH: begin
               if (!s.hit && (op.run_length != '0)) begin
                  if (word_in[j]) begin
                     s.run_begin = RUN_W'(bit_idx + CW'(1));
                     s.zeros     = '0;
                  end else begin
                     s.zeros = s.zeros + LEN_W'(1);
                     if (s.zeros == op.run_length) begin
                        s.hit   = 1'b1;
                        s.where = s.run_begin;
                     end
                  end
               end
            end
            CMD_ALLOC: begin
               if (in_range) begin
                  w[j] = 1'b1;
               end
            end
            CMD_FREE: begin
               if (in_range) begin
                  w[j] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      srch_out = s;
      word_out = w;
   end

endmodule

`default_nettype wire

### hw/rtl/bitmap_first_fit_allocator.sv
// channel   dir  signals                       contents
// req       in   req_tvalid/tready/tdata/tuser  tdata: start_bit, run_length; tuser: cmd
// rsp       out  rsp_tvalid/tready/tdata/tuser  tdata: run_start; tuser: found
//
// every command walks the whole map, one byte word per cycle through the
// single-port-read bitmap memory
// after reset a clearing pass writes all MAP_BYTES words to free, during which
// req_tready stays low
// a new command is taken while a result still waits on rsp; the scan then
// holds in its response state until the output register frees up
`default_nettype none

module bitmap_first_fit_allocator
   import bffa_pkg::*;
#(
   parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] start_bit, [16:8] run_length
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] run_start
   output logic             rsp_tuser    // [0] found
);

   localparam int unsigned AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int unsigned BIT_W = AW + 3;

   state_type       state_ff, state_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic            proc_vld_ff;
   logic [AW-1:0]   proc_addr_ff;
   op_type          op_ff;
   search_type      srch_ff;
   search_type      srch_nxt;
   logic            rsp_valid_ff;
   logic            rsp_found_ff;
   logic [RUN_W-1:0] rsp_start_ff;

   logic              rd_en;
   logic              clr_wr;
   logic              load_rsp;
   logic              last_word;
   logic              req_xfer;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] new_word;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;

   assign last_word = (cnt_ff == AW'(MAP_BYTES - 1));
   assign req_xfer  = req_tvalid && req_tready;

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rd_en      = 1'b0;
      clr_wr     = 1'b0;
      load_rsp   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_wr = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (last_word) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (last_word) begin
               cnt_in   = '0;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         proc_vld_ff <= rd_en;
      end
   end

   // word address that matches the read data
   always_ff @(posedge clock) begin
      proc_addr_ff <= cnt_ff;
   end

   // command capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff.cmd        <= cmd_type'(req_tuser);
         op_ff.start_bit  <= req_tdata[7:0];
         op_ff.run_length <= req_tdata[16:8];
      end
   end

   // search state, cleared per command
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         srch_ff <= '0;
      end else if (proc_vld_ff) begin
         srch_ff <= srch_nxt;
      end
   end

   // bitmap storage
   assign wr_en   = clr_wr || proc_vld_ff;
   assign wr_addr = clr_wr ? cnt_ff : proc_addr_ff;
   assign wr_data = clr_wr ? '0 : new_word;

   bffa_mem #(
      .DEPTH (MAP_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // per-word search and mark datapath
   bffa_word #(
      .BIT_W (BIT_W)
   ) u_word (
      .op       (op_ff),
      .base     ({proc_addr_ff, 3'b000}),
      .word_in  (rd_data),
      .srch_in  (srch_ff),
      .word_out (new_word),
      .srch_out (srch_nxt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff <= srch_ff.hit;
         rsp_start_ff <= srch_ff.where;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_start_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire

### hw/rtl/bffa_chk.sv
`default_nettype none

`include "bitmap_first_fit_allocator_macros.svh"

module bffa_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tuser
);

   // a held result keeps its contents
   `BFFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a miss or a mark command reports start zero
   `BFFA_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 8'd0)

   // the clearing pass blocks commands right after reset
   `BFFA_ASSERT_NEXT(a_clear_block, clock, 1'b0, reset, !req_tready)

   // one command at a time: a transfer closes the request side
   `BFFA_ASSERT_NEXT(a_one_cmd, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind bitmap_first_fit_allocator bffa_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
